FILE: hdl/izh_pkg.sv
// Shared types, constants and fixed-point helpers for the Izhikevich RK4 neuron.
package izh_pkg;

  localparam int QW   = 32;  // Q16.16 word
  localparam int FRAC = 16;
  localparam int HW   = 17;  // step size width
  localparam int NW   = 8;   // noise offset width
  localparam int AW   = 36;  // RK4 slope sum and multiplier A operand
  localparam int PW   = AW + QW;  // product width
  localparam int QDW  = 37;  // scaled increment before the divide by six
  localparam int IDXW = 3;

  localparam logic [IDXW-1:0] REG_A  = 3'd0;
  localparam logic [IDXW-1:0] REG_B  = 3'd1;
  localparam logic [IDXW-1:0] REG_C  = 3'd2;
  localparam logic [IDXW-1:0] REG_D  = 3'd3;
  localparam logic [IDXW-1:0] REG_K  = 3'd4;
  localparam logic [IDXW-1:0] REG_VR = 3'd5;
  localparam logic [IDXW-1:0] REG_VT = 3'd6;
  localparam logic [IDXW-1:0] REG_H  = 3'd7;

  localparam logic signed [QW-1:0] RST_A  = 32'sd65536;
  localparam logic signed [QW-1:0] RST_B  = 32'sd32768;
  localparam logic signed [QW-1:0] RST_C  = -32'sd1966080;
  localparam logic signed [QW-1:0] RST_D  = 32'sd524288;
  localparam logic signed [QW-1:0] RST_K  = 32'sd32768;
  localparam logic signed [QW-1:0] RST_VR = -32'sd3932160;
  localparam logic signed [QW-1:0] RST_VT = -32'sd3276800;
  localparam logic [HW-1:0]        RST_H  = 17'd6554;

  localparam logic signed [QW-1:0] Q_ONE = 32'sd65536;

  localparam int DIV_STEPS = 5;  // byte digits of the 40-bit dividend
  localparam int DCW       = 3;

  typedef struct packed {
    logic signed [QW-1:0] a;
    logic signed [QW-1:0] b;
    logic signed [QW-1:0] c;
    logic signed [QW-1:0] d;
    logic signed [QW-1:0] k;
    logic signed [QW-1:0] vr;
    logic signed [QW-1:0] vt;
    logic [HW-1:0]        h;
  } cfg_t;

  typedef enum logic [3:0] {
    M_NONE, M_K_DVR, M_B_DVR, M_P1_DVT, M_A_W, M_H_KV, M_H_KU, M_H_SV, M_H_SU
  } mul_sel_t;

  typedef enum logic [3:0] {
    WB_NONE, WB_P1, WB_T, WB_KV, WB_KU, WB_VS, WB_US, WB_QV, WB_QU, WB_NEW
  } wb_sel_t;

  typedef struct packed {
    logic     capture;
    logic     diff;
    mul_sel_t mul;
    wb_sel_t  wb;
    logic     half;
    logic     dbl;
    logic     acc_v;
    logic     acc_u;
    logic     div_start;
    logic     commit;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
    logic is_load;
  } status_t;

  localparam logic signed [PW-1:0] SAT_HI = PW'(32'sh7fff_ffff);
  localparam logic signed [PW-1:0] SAT_LO = $signed({{(PW-QW){1'b1}}, 32'h8000_0000});

  function automatic logic signed [QW-1:0] sat32(input logic signed [PW-1:0] x);
    logic signed [QW-1:0] r;
    if (x > SAT_HI) begin
      r = 32'sh7fff_ffff;
    end else if (x < SAT_LO) begin
      r = $signed(32'h8000_0000);
    end else begin
      r = x[QW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [PW-1:0] ext32(input logic signed [QW-1:0] x);
    return $signed({{(PW-QW){x[QW-1]}}, x});
  endfunction

endpackage

FILE: hdl/izh_div6.sv
// Floor division of a scaled increment by six, one byte digit per cycle.
module izh_div6
  import izh_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic signed [QDW-1:0] num,
  output logic                  done,
  output logic signed [QDW-1:0] res
);

  logic [39:0]       y;
  logic [39:0]       quot;
  logic [1:0]        rem;
  logic              busy;
  logic [DCW-1:0]    cnt;
  logic signed [39:0] ysum;
  logic [9:0]        chunk;
  logic [19:0]       recip;
  logic [7:0]        qd;
  logic [9:0]        three_q;
  logic [9:0]        rem_full;

  // floor(n/6) = floor(floor(n/2)/3); a bias of 3*2^35 keeps the dividend positive.
  assign ysum     = ($signed({{3{num[QDW-1]}}, num}) >>> 1) + 40'sh18_0000_0000;
  assign chunk    = {rem, y[39:32]};
  assign recip    = chunk * 10'd683;
  assign qd       = recip[18:11];
  assign three_q  = {1'b0, qd, 1'b0} + {2'b00, qd};
  assign rem_full = chunk - three_q;
  assign res      = $signed({1'b0, quot[35:0]}) - 37'sh8_0000_0000;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DCW'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      y    <= ysum;
      quot <= '0;
      rem  <= '0;
    end else if (busy) begin
      y    <= {y[31:0], 8'h00};
      quot <= {quot[31:0], qd};
      rem  <= rem_full[1:0];
    end
  end

endmodule

FILE: hdl/izh_datapath.sv
// Datapath: state, shared multiplier, RK4 stage registers, divider lanes, result register.
module izh_datapath
  import izh_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  cfg_t                 cfg,
  input  cmd_t                 cmd,
  output status_t              status,
  input  logic                 req_type,
  input  logic signed [QW-1:0] load_potential,
  input  logic signed [QW-1:0] load_recovery,
  input  logic signed [NW-1:0] noise_offset,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [QW-1:0] potential_out,
  output logic signed [QW-1:0] recovery_out,
  output logic                 spiked
);

  logic signed [QW-1:0]  v, u;
  logic signed [QW-1:0]  vs, us, dvr, dvt, p1, t, w, kv, ku;
  logic signed [QW-1:0]  ld_v, ld_u, nv1, nu1;
  logic signed [NW-1:0]  noise;
  logic                  is_load;
  logic signed [AW-1:0]  sv, su;
  logic signed [PW-1:0]  prod;
  logic signed [QDW-1:0] qv, qu, resv, resu;
  logic                  donev, doneu;
  logic signed [AW-1:0]  mul_a;
  logic signed [QW-1:0]  mul_b;
  logic signed [QW-1:0]  h_s;
  logic signed [PW-1:0]  prod_sh;
  logic signed [QW-1:0]  prod_q;
  logic signed [QW-1:0]  step_q;
  logic signed [AW-1:0]  kv_term, ku_term;
  logic signed [QW-1:0]  nvn;

  assign h_s     = $signed({{(QW-HW){1'b0}}, cfg.h});
  assign prod_sh = prod >>> FRAC;
  assign prod_q  = sat32(prod_sh);
  assign step_q  = cmd.half ? sat32(prod >>> (FRAC + 1)) : prod_q;
  assign kv_term = cmd.dbl ? ($signed({{(AW-QW){kv[QW-1]}}, kv}) <<< 1)
                           : $signed({{(AW-QW){kv[QW-1]}}, kv});
  assign ku_term = cmd.dbl ? ($signed({{(AW-QW){ku[QW-1]}}, ku}) <<< 1)
                           : $signed({{(AW-QW){ku[QW-1]}}, ku});
  assign nvn = sat32(ext32(nv1) + $signed({{(PW-NW-FRAC){noise[NW-1]}}, noise, 16'h0000}));

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.mul)
      M_NONE:   begin mul_a = '0; mul_b = '0; end
      M_K_DVR:  begin mul_a = AW'(cfg.k); mul_b = dvr; end
      M_B_DVR:  begin mul_a = AW'(cfg.b); mul_b = dvr; end
      M_P1_DVT: begin mul_a = AW'(p1); mul_b = dvt; end
      M_A_W:    begin mul_a = AW'(cfg.a); mul_b = w; end
      M_H_KV:   begin mul_a = AW'(kv); mul_b = h_s; end
      M_H_KU:   begin mul_a = AW'(ku); mul_b = h_s; end
      M_H_SV:   begin mul_a = sv; mul_b = h_s; end
      M_H_SU:   begin mul_a = su; mul_b = h_s; end
      default:  begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (cmd.capture) begin
      is_load <= req_type;
      ld_v    <= load_potential;
      ld_u    <= load_recovery;
      noise   <= noise_offset;
      vs      <= v;
      us      <= u;
      sv      <= '0;
      su      <= '0;
    end
    if (cmd.diff) begin
      dvr <= sat32(ext32(vs) - ext32(cfg.vr));
      dvt <= sat32(ext32(vs) - ext32(cfg.vt));
    end
    if (cmd.acc_v) sv <= sv + kv_term;
    if (cmd.acc_u) su <= su + ku_term;
    unique case (cmd.wb)
      WB_NONE: ;
      WB_P1:   p1 <= prod_q;
      WB_T:    t <= prod_q;
      WB_KV: begin
        kv <= sat32(ext32(prod_q) - ext32(us));
        w  <= sat32(ext32(t) - ext32(us));
      end
      WB_KU:   ku <= prod_q;
      WB_VS:   vs <= sat32(ext32(v) + ext32(step_q));
      WB_US:   us <= sat32(ext32(u) + ext32(step_q));
      WB_QV:   qv <= prod_sh[QDW-1:0];
      WB_QU:   qu <= prod_sh[QDW-1:0];
      WB_NEW: begin
        nv1 <= sat32(ext32(v) + $signed({{(PW-QDW){resv[QDW-1]}}, resv}));
        nu1 <= sat32(ext32(u) + $signed({{(PW-QDW){resu[QDW-1]}}, resu}));
      end
      default: ;
    endcase
  end

  izh_div6 u_div_v (
    .clk(clk), .rst(rst), .start(cmd.div_start), .num(qv), .done(donev), .res(resv)
  );
  izh_div6 u_div_u (
    .clk(clk), .rst(rst), .start(cmd.div_start), .num(qu), .done(doneu), .res(resu)
  );

  // Neuron state and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      v         <= '0;
      u         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_ready) out_valid <= 1'b0;
      if (cmd.commit) begin
        out_valid <= 1'b1;
        if (is_load) begin
          v <= ld_v;
          u <= ld_u;
        end else if (nvn >= Q_ONE) begin
          v <= cfg.c;
          u <= sat32(ext32(u) + ext32(cfg.d));
        end else begin
          v <= nvn;
          u <= nu1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (is_load) begin
        potential_out <= ld_v;
        recovery_out  <= ld_u;
        spiked        <= 1'b0;
      end else if (nvn >= Q_ONE) begin
        potential_out <= cfg.c;
        recovery_out  <= sat32(ext32(u) + ext32(cfg.d));
        spiked        <= 1'b1;
      end else begin
        potential_out <= nvn;
        recovery_out  <= nu1;
        spiked        <= 1'b0;
      end
    end
  end

  assign status.div_done = donev & doneu;
  assign status.out_free = ~out_valid | out_ready;
  assign status.is_load  = is_load;

endmodule

FILE: hdl/izh_ctrl.sv
// Controller: sequences the RK4 stages, final scaling, divide and commit.
module izh_ctrl
  import izh_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  logic    req_type,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_STAGE  = 5'b00010,
    S_FINAL  = 5'b00100,
    S_DIV    = 5'b01000,
    S_COMMIT = 5'b10000
  } state_t;

  state_t     state, state_next;
  logic [1:0] stage, stage_next;
  logic [3:0] step, step_next;
  logic       last_stage;

  assign last_stage = (stage == 2'd3);
  assign in_ready   = (state == S_IDLE);

  always_comb begin
    state_next = state;
    stage_next = stage;
    step_next  = step;
    cmd        = '0;
    cmd.mul    = M_NONE;
    cmd.wb     = WB_NONE;
    cmd.half   = (stage == 2'd0) || (stage == 2'd1);
    cmd.dbl    = (stage == 2'd1) || (stage == 2'd2);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          stage_next  = '0;
          step_next   = '0;
          state_next  = req_type ? S_COMMIT : S_STAGE;
        end
      end
      S_STAGE: begin
        step_next = step + 1'b1;
        case (step)
          4'd0: cmd.diff = 1'b1;
          4'd1: cmd.mul = M_K_DVR;
          4'd2: begin cmd.wb = WB_P1; cmd.mul = M_B_DVR; end
          4'd3: begin cmd.wb = WB_T;  cmd.mul = M_P1_DVT; end
          4'd4: cmd.wb = WB_KV;
          4'd5: begin cmd.mul = M_A_W; cmd.acc_v = 1'b1; end
          4'd6: begin
            cmd.wb = WB_KU;
            if (!last_stage) cmd.mul = M_H_KV;
          end
          4'd7: begin
            cmd.acc_u = 1'b1;
            if (last_stage) begin
              step_next  = '0;
              state_next = S_FINAL;
            end else begin
              cmd.mul = M_H_KU;
              cmd.wb  = WB_VS;
            end
          end
          4'd8: begin
            cmd.wb     = WB_US;
            step_next  = '0;
            stage_next = stage + 1'b1;
          end
          default: step_next = '0;
        endcase
      end
      S_FINAL: begin
        step_next = step + 1'b1;
        case (step)
          4'd0: cmd.mul = M_H_SV;
          4'd1: begin cmd.wb = WB_QV; cmd.mul = M_H_SU; end
          4'd2: cmd.wb = WB_QU;
          default: begin
            cmd.div_start = 1'b1;
            step_next     = '0;
            state_next    = S_DIV;
          end
        endcase
      end
      S_DIV: begin
        if (status.div_done) begin
          cmd.wb     = WB_NEW;
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      stage <= '0;
      step  <= '0;
    end else begin
      state <= state_next;
      stage <= stage_next;
      step  <= step_next;
    end
  end

endmodule

FILE: hdl/izhikevich_neuron_rk4_step.sv
// Izhikevich neuron with one fixed-point RK4 step per tick: top level.
// An advance item passes through the RK stages, final scaling and divide before it commits;
// a load item goes straight to commit. One item is in work at a time; the four
// dependent RK stages share one 36x32 multiplier, and a byte-serial divide by six ends it.
// The result register lets the next item transfer while a result still waits.
// Synchronous reset clears the state to zero and the registers to their defaults.
module izhikevich_neuron_rk4_step
  import izh_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [IDXW-1:0]      cfg_index,
  input  logic [QW-1:0]        cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 req_type,
  input  logic signed [QW-1:0] load_potential,
  input  logic signed [QW-1:0] load_recovery,
  input  logic signed [NW-1:0] noise_offset,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [QW-1:0] potential_out,
  output logic signed [QW-1:0] recovery_out,
  output logic                 spiked
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  // Configuration registers. The user must write them only while no item is in work; the
  // block does not enforce it. The datapath reads them directly without a shadow copy.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.a  <= RST_A;
      cfg.b  <= RST_B;
      cfg.c  <= RST_C;
      cfg.d  <= RST_D;
      cfg.k  <= RST_K;
      cfg.vr <= RST_VR;
      cfg.vt <= RST_VT;
      cfg.h  <= RST_H;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_A:   cfg.a  <= $signed(cfg_data);
        REG_B:   cfg.b  <= $signed(cfg_data);
        REG_C:   cfg.c  <= $signed(cfg_data);
        REG_D:   cfg.d  <= $signed(cfg_data);
        REG_K:   cfg.k  <= $signed(cfg_data);
        REG_VR:  cfg.vr <= $signed(cfg_data);
        REG_VT:  cfg.vt <= $signed(cfg_data);
        REG_H:   cfg.h  <= cfg_data[HW-1:0];
        default: ;
      endcase
    end
  end

  // The controller steps each RK stage through the shared multiplier, then scales
  // the weighted slope sums by h/6 and commits the spike test to the state.
  izh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .req_type (req_type),
    .status   (status),
    .cmd      (cmd)
  );

  izh_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .cmd            (cmd),
    .status         (status),
    .req_type       (req_type),
    .load_potential (load_potential),
    .load_recovery  (load_recovery),
    .noise_offset   (noise_offset),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .potential_out  (potential_out),
    .recovery_out   (recovery_out),
    .spiked         (spiked)
  );

endmodule

FILE: hdl/izh_checker.sv
// Port-level checker for the neuron block and its bind to the top level.
module izh_port_checker
  import izh_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 req_type,
  input logic signed [QW-1:0] load_potential,
  input logic signed [QW-1:0] load_recovery,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic signed [QW-1:0] potential_out,
  input logic signed [QW-1:0] recovery_out,
  input logic                 spiked
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(potential_out) && $stable(spiked))
    else $error("stalled result changed");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second transfer taken while an item is in work");

  a_load_echo: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && req_type && !out_valid |=> ##1
      (out_valid && !spiked && potential_out == $past(load_potential, 2)
       && recovery_out == $past(load_recovery, 2)))
    else $error("load item not echoed");

endmodule

bind izhikevich_neuron_rk4_step izh_port_checker u_izh_checker (.*);

FILE: sim/izh_checker.sv
// Checker for the Izhikevich RK4 neuron: predicts each result and compares it with the block.
module izh_checker
  import izh_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [IDXW-1:0]      cfg_index,
  input  logic [QW-1:0]        cfg_data,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic                 req_type,
  input  logic signed [QW-1:0] load_potential,
  input  logic signed [QW-1:0] load_recovery,
  input  logic signed [NW-1:0] noise_offset,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic signed [QW-1:0] potential_out,
  input  logic signed [QW-1:0] recovery_out,
  input  logic                 spiked,
  output int                   errors,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [QW-1:0] pot;
    logic signed [QW-1:0] rec;
    logic                 spk;
  } neuron_result_t;

  neuron_result_t       awaited_results[$];
  logic [QW-1:0]        regs[8];
  logic signed [QW-1:0] cur_v;
  logic signed [QW-1:0] cur_u;

  function automatic longint clamp32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint floor_div(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q = q - 1;
    return q;
  endfunction

  function automatic longint fx_mul(longint x, longint y, longint d);
    return clamp32(floor_div(x * y, d));
  endfunction

  function automatic longint dv_slope(longint v, longint u, longint k, longint vr, longint vt);
    longint p;
    p = fx_mul(k, clamp32(v - vr), 65536);
    p = fx_mul(p, clamp32(v - vt), 65536);
    return clamp32(p - u);
  endfunction

  function automatic longint du_slope(longint v, longint u, longint a, longint b, longint vr);
    longint t;
    t = fx_mul(b, clamp32(v - vr), 65536);
    return fx_mul(a, clamp32(t - u), 65536);
  endfunction

  // Advance the neuron by one RK4 step (or load it) and return the new state.
  function automatic neuron_result_t advance_neuron(logic rt, logic signed [QW-1:0] lp,
                                                    logic signed [QW-1:0] lr,
                                                    logic signed [NW-1:0] nz);
    neuron_result_t r;
    longint a, b, c, d, k, vr, vt, h, v, u, vs, us, sv, su, nv, nu, dv;
    longint kv[4];
    longint ku[4];
    a  = longint'($signed(regs[REG_A]));
    b  = longint'($signed(regs[REG_B]));
    c  = longint'($signed(regs[REG_C]));
    d  = longint'($signed(regs[REG_D]));
    k  = longint'($signed(regs[REG_K]));
    vr = longint'($signed(regs[REG_VR]));
    vt = longint'($signed(regs[REG_VT]));
    h  = longint'(regs[REG_H][HW-1:0]);
    v  = longint'(cur_v);
    u  = longint'(cur_u);
    if (rt) begin
      r.pot = lp;
      r.rec = lr;
      r.spk = 1'b0;
      return r;
    end
    kv[0] = dv_slope(v, u, k, vr, vt);
    ku[0] = du_slope(v, u, a, b, vr);
    for (int s = 1; s < 4; s++) begin
      dv = (s < 3) ? 131072 : 65536;
      vs = clamp32(v + fx_mul(h, kv[s-1], dv));
      us = clamp32(u + fx_mul(h, ku[s-1], dv));
      kv[s] = dv_slope(vs, us, k, vr, vt);
      ku[s] = du_slope(vs, us, a, b, vr);
    end
    sv = kv[0] + 2 * kv[1] + 2 * kv[2] + kv[3];
    su = ku[0] + 2 * ku[1] + 2 * ku[2] + ku[3];
    nv = clamp32(v + floor_div(h * sv, 6 * 65536));
    nu = clamp32(u + floor_div(h * su, 6 * 65536));
    nv = clamp32(nv + longint'(nz) * 65536);
    r.spk = 1'b0;
    if (nv >= 65536) begin
      nv = c;
      nu = clamp32(u + d);
      r.spk = 1'b1;
    end
    r.pot = nv[QW-1:0];
    r.rec = nu[QW-1:0];
    return r;
  endfunction

  assign pending = awaited_results.size();

  always @(posedge clk) begin
    neuron_result_t want;
    if (rst) begin
      regs[REG_A]  <= RST_A;
      regs[REG_B]  <= RST_B;
      regs[REG_C]  <= RST_C;
      regs[REG_D]  <= RST_D;
      regs[REG_K]  <= RST_K;
      regs[REG_VR] <= RST_VR;
      regs[REG_VT] <= RST_VT;
      regs[REG_H]  <= QW'(RST_H);
      cur_v <= '0;
      cur_u <= '0;
      awaited_results.delete();
      errors <= 0;
    end else begin
      if (cfg_write) begin
        regs[cfg_index] <= (cfg_index == REG_H) ? (cfg_data & 32'h1_ffff) : cfg_data;
      end
      if (in_valid && in_ready) begin
        want = advance_neuron(req_type, load_potential, load_recovery, noise_offset);
        cur_v <= want.pot;
        cur_u <= want.rec;
        awaited_results.push_back(want);
      end
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result pot=%h rec=%h spk=%b",
                   $time, potential_out, recovery_out, spiked);
          errors <= errors + 1;
        end else begin
          want = awaited_results.pop_front();
          if (want.pot !== potential_out || want.rec !== recovery_out ||
              want.spk !== spiked) begin
            $display("%0t: mismatch expected pot=%h rec=%h spk=%b, actual pot=%h rec=%h spk=%b",
                     $time, want.pot, want.rec, want.spk,
                     potential_out, recovery_out, spiked);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

FILE: sim/tb_izhikevich_neuron_rk4_step.sv
// Testbench top for the Izhikevich RK4 neuron: stimulus, configuration phases and verdict.
module tb_izhikevich_neuron_rk4_step;
  import izh_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [IDXW-1:0]      cfg_index = '0;
  logic [QW-1:0]        cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 req_type = 1'b0;
  logic signed [QW-1:0] load_potential = '0;
  logic signed [QW-1:0] load_recovery = '0;
  logic signed [NW-1:0] noise_offset = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [QW-1:0] potential_out;
  logic signed [QW-1:0] recovery_out;
  logic                 spiked;
  int                   errors;
  int                   pending;
  int                   cycle_count = 0;
  int                   burst_left = 0;

  // The clock runs at a 10 ns period.
  always #5 clk = ~clk;

  izhikevich_neuron_rk4_step DUT (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .req_type(req_type),
    .load_potential(load_potential), .load_recovery(load_recovery),
    .noise_offset(noise_offset),
    .out_valid(out_valid), .out_ready(out_ready), .potential_out(potential_out),
    .recovery_out(recovery_out), .spiked(spiked)
  );

  izh_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .req_type(req_type),
    .load_potential(load_potential), .load_recovery(load_recovery),
    .noise_offset(noise_offset),
    .out_valid(out_valid), .out_ready(out_ready), .potential_out(potential_out),
    .recovery_out(recovery_out), .spiked(spiked),
    .errors(errors), .pending(pending)
  );

  // The cycle counter guards against a hung handshake. A correct run has roughly
  // 1000 items, so this limit is generous.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 3000000) begin
      $display("tb_izhikevich_neuron_rk4_step: done, errors");
      $finish;
    end
  end

  // The receiver switches between three habits: always ready, random coin flips,
  // and long stalls broken by short ready windows. The habit changes every so often.
  int rx_mode = 0;
  int rx_left = 0;
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(2, 0);
      rx_left = $urandom_range(400, 20);
    end
    rx_left = rx_left - 1;
    case (rx_mode)
      0: begin
        out_ready = 1'b1;
      end
      1: begin
        out_ready = $urandom_range(1, 0);
      end
      default: begin
        out_ready = ($urandom_range(15, 0) == 0);
      end
    endcase
  end

  // Write one configuration register across a single rising edge.
  task automatic write_reg(input logic [IDXW-1:0] idx, input logic [QW-1:0] data);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  // Wait until every transfer has produced its result, then let the pipeline settle.
  task automatic drain;
    @(negedge clk);
    in_valid = 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  // Present one item and hold it until the block takes it. Items go out in bursts;
  // between bursts the valid line drops for a random gap. Within a burst valid
  // stays high from one item to the next.
  task automatic send_item(input logic rt, input logic signed [QW-1:0] lp,
                           input logic signed [QW-1:0] lr, input logic signed [NW-1:0] nz);
    logic taken;
    if (burst_left == 0) begin
      if (in_valid) @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(3, 0) == 0 ? $urandom_range(120, 1) : $urandom_range(4, 0))
        @(negedge clk);
      burst_left = $urandom_range(12, 1);
    end else if (in_valid) begin
      @(negedge clk);
    end
    burst_left = burst_left - 1;
    in_valid       = 1'b1;
    req_type       = rt;
    load_potential = lp;
    load_recovery  = lr;
    noise_offset   = nz;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = in_ready;
    end
  endtask

  // Write all eight registers with one setting.
  task automatic write_all(input logic [QW-1:0] a, input logic [QW-1:0] b,
                           input logic [QW-1:0] c, input logic [QW-1:0] d,
                           input logic [QW-1:0] k, input logic [QW-1:0] vr,
                           input logic [QW-1:0] vt, input logic [QW-1:0] h);
    write_reg(REG_A, a);
    write_reg(REG_B, b);
    write_reg(REG_C, c);
    write_reg(REG_D, d);
    write_reg(REG_K, k);
    write_reg(REG_VR, vr);
    write_reg(REG_VT, vt);
    write_reg(REG_H, h);
  endtask

  function automatic logic [QW-1:0] near(input int base, input int spread);
    return QW'(base + $signed($urandom_range(2 * spread, 0)) - spread);
  endfunction

  // Random traffic: mostly ticks with small noise, between occasional loads of a plausible
  // state, so the neuron charges up and spikes; the rest are full-range loads or noise.
  task automatic random_items(input int count);
    int sel;
    logic signed [NW-1:0] nz;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(99, 0);
      nz = ($urandom_range(7, 0) == 0) ? NW'($urandom) : NW'($urandom_range(6, 0) - 3);
      if (sel < 8) begin
        send_item(1'b1, near(-60 * 65536, 20 * 65536), near(0, 10 * 65536), NW'($urandom));
      end else if (sel < 15) begin
        send_item(1'b1, $urandom, $urandom, NW'($urandom));
      end else begin
        send_item(1'b0, $urandom, $urandom, nz);
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part under the reset defaults: extreme loads, extreme noise,
    // saturation of the state, and a driven spike.
    send_item(1'b0, '0, '0, '0);
    send_item(1'b1, 32'sh7fff_ffff, $signed(32'h8000_0000), 8'sh7f);
    send_item(1'b0, '0, '0, 8'sh7f);
    send_item(1'b1, $signed(32'h8000_0000), 32'sh7fff_ffff, 8'sh80);
    send_item(1'b0, '0, '0, 8'sh80);
    send_item(1'b0, '0, '0, 8'sh80);
    send_item(1'b1, -32'sd3932160, '0, '0);
    send_item(1'b0, '0, '0, '0);
    send_item(1'b0, '0, '0, 8'sd80);
    send_item(1'b0, '0, '0, 8'sh7f);
    send_item(1'b1, 32'sd65535, '0, '0);
    send_item(1'b0, '0, '0, '0);
    send_item(1'b1, -32'sd65536, 32'sh7fff_0000, 8'sd1);
    send_item(1'b0, '0, '0, 8'sd2);
    drain();

    // Large step and all registers at their maximum: the stages saturate.
    write_all(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
              32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0001_ffff);
    send_item(1'b1, -32'sd3932160, 32'sd1000, '0);
    send_item(1'b0, '0, '0, '0);
    send_item(1'b0, '0, '0, 8'sh80);
    send_item(1'b1, 32'sh7fff_ffff, 32'sh7fff_ffff, '0);
    send_item(1'b0, '0, '0, 8'sh7f);
    random_items(60);
    drain();

    // Registers at their minimum with a zero step.
    write_all(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0000_0000);
    send_item(1'b1, $signed(32'h8000_0000), $signed(32'h8000_0000), '0);
    send_item(1'b0, '0, '0, 8'sh80);
    random_items(60);
    drain();

    // Plausible neuron settings with jitter, a step of up to one time unit.
    for (int ph = 0; ph < 6; ph++) begin
      write_all(near(1311, 1300), near(13107, 13000), near(-65 * 65536, 10 * 65536),
                near(8 * 65536, 6 * 65536), near(45875, 40000),
                near(-60 * 65536, 5 * 65536), near(-40 * 65536, 5 * 65536),
                $urandom_range(65536, 0));
      random_items(90);
      drain();
    end

    // Fully random registers, including steps above one time unit.
    for (int ph = 0; ph < 2; ph++) begin
      write_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom);
      random_items(60);
      drain();
    end

    // Back to the defaults for a final stretch.
    write_all(RST_A, RST_B, RST_C, RST_D, RST_K, RST_VR, RST_VT, QW'(RST_H));
    random_items(90);
    drain();

    if (errors == 0 && pending == 0) begin
      $display("tb_izhikevich_neuron_rk4_step: done, clean");
    end else begin
      $display("tb_izhikevich_neuron_rk4_step: done, errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/izh_pkg.sv
hdl/izh_div6.sv
hdl/izh_datapath.sv
hdl/izh_ctrl.sv
hdl/izhikevich_neuron_rk4_step.sv
hdl/izh_checker.sv
sim/izh_checker.sv
sim/tb_izhikevich_neuron_rk4_step.sv
